// ----- rtl/core/multiphase_triangle_lfo_defines.svh -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO assertion macros
// Concurrent assertion helpers, removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTIPHASE_TRIANGLE_LFO_DEFINES_SVH
`define MULTIPHASE_TRIANGLE_LFO_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTLFO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtlfo: assertion failed");

// next-cycle implication
`define MTLFO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtlfo: assertion failed");

`else

`define MTLFO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTLFO_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mtlfo_pkg.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO package
// Widths, constants, register map, controller states and shared types.
// ----------------------------------------------------------------------------
package mtlfo_pkg;

    // field widths
    localparam int VOLT_W     = 17;   // Q4.12 volts
    localparam int DIFF_W     = VOLT_W + 1;
    localparam int BPM_W      = 15;   // Q9.6
    localparam int STEP_W     = 24;
    localparam int PHASE_W    = 32;   // Q0.32 turns
    localparam int COUNT_W    = 5;
    localparam int CH_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_CHANNELS_DEF = 16;

    // rate from CV: round(cv * gain / 2^22) + offset
    localparam int RATE_GAIN   = 1638072;   // 24.995 * 2^16
    localparam int RATE_OFFSET = 16003;     // 250.05 * 64
    localparam int RATE_SHIFT  = 22;
    localparam int RATE_ROUND  = 2 ** (RATE_SHIFT - 1);
    localparam int RATE_PROD_W = VOLT_W + 22;
    localparam int BPM_RAW_W   = RATE_PROD_W - RATE_SHIFT + 2;
    localparam int BPM_MAX     = 32767;

    // phase increment = (bpm * step) >> 12
    localparam int INC_SHIFT  = 12;
    localparam int INC_PROD_W = BPM_W + STEP_W;
    localparam int INC_W      = INC_PROD_W - INC_SHIFT;

    // level = lo + round(diff * mag / 2^31)
    localparam int HALF_W      = PHASE_W / 2;
    localparam int PPROD_W     = DIFF_W + HALF_W + 1;
    localparam int ACC_W       = DIFF_W + PHASE_W + 1;
    localparam int LEVEL_SHIFT = PHASE_W - 1;
    localparam logic [ACC_W-1:0] LEVEL_ROUND = ACC_W'(1) << (LEVEL_SHIFT - 1);

    // 2^32 / n, two quotient bits a cycle over a 34-bit dividend
    localparam int DIV_PAIRS  = (PHASE_W + 2) / 2;
    localparam int PREP_CNT_W = $clog2(DIV_PAIRS);
    localparam int PREP_LAST  = DIV_PAIRS - 1;

    // sequencing of the rate datapath inside the divider sweep
    localparam int PREP_RATE_MUL = 0;
    localparam int PREP_BPM      = 1;
    localparam int PREP_INC      = 2;
    localparam int PREP_ADD      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 4'd0,
        REG_RATE_KNOB_BPM = 4'd1,
        REG_MIN_KNOB      = 4'd2,
        REG_MAX_KNOB      = 4'd3,
        REG_USE_RATE_CV   = 4'd4,
        REG_USE_MIN_CV    = 4'd5,
        REG_USE_MAX_CV    = 4'd6,
        REG_STEP_PER_BPM  = 4'd7
    } t_reg_idx;

    localparam logic [COUNT_W-1:0]       RST_CHANNEL_COUNT = 5'd1;
    localparam logic [BPM_W-1:0]         RST_RATE_KNOB_BPM = 15'd7680;
    localparam logic signed [VOLT_W-1:0] RST_MIN_KNOB      = -17'sd20480;
    localparam logic signed [VOLT_W-1:0] RST_MAX_KNOB      = 17'sd20480;
    localparam logic [STEP_W-1:0]        RST_STEP_PER_BPM  = 24'd95443;

    typedef struct packed {
        logic [COUNT_W-1:0]       channel_count;
        logic [BPM_W-1:0]         rate_knob_bpm;
        logic signed [VOLT_W-1:0] min_knob;
        logic signed [VOLT_W-1:0] max_knob;
        logic                     use_rate_cv;
        logic                     use_min_cv;
        logic                     use_max_cv;
        logic [STEP_W-1:0]        step_per_bpm;
    } t_cfg;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_PH   = 6'b000100,
        S_MLO  = 6'b001000,
        S_MHI  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    typedef struct packed {
        logic start;      // latch item, clear channel walk and divider
        logic div_step;   // two quotient bits
        logic div_first;  // top dividend pair
        logic rate_mul;
        logic bpm_sel;
        logic inc_mul;
        logic phase_add;
        logic mag;
        logic mlo;
        logic mhi;
        logic load_out;   // output register takes the level, walk advances
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic last_ch;
        logic out_free;
    } t_sts;

    // one restoring division step: returns {quotient bit, remainder}
    function automatic logic [COUNT_W:0] div_step(input logic [COUNT_W-1:0] rem,
                                                   input logic dbit,
                                                   input logic [COUNT_W-1:0] dvs);
        logic [COUNT_W:0] t;
        logic [COUNT_W:0] d;
        t = {rem, dbit};
        d = {1'b0, dvs};
        if (t >= d) begin
            return {1'b1, COUNT_W'(t - d)};
        end
        return {1'b0, t[COUNT_W-1:0]};
    endfunction

endpackage

// ----- rtl/core/mtlfo_if.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO channel interfaces
// Valid/ready channels for sample ticks, levels and register writes.
// ----------------------------------------------------------------------------
interface mtlfo_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mtlfo_pkg::VOLT_W-1:0]       rate_cv;
    logic signed [mtlfo_pkg::VOLT_W-1:0]       min_cv;
    logic signed [mtlfo_pkg::VOLT_W-1:0]       max_cv;

    modport source (output valid, rate_cv, min_cv, max_cv, input ready);
    modport sink   (input valid, rate_cv, min_cv, max_cv, output ready);
endinterface

interface mtlfo_out_if;
    logic                                valid;
    logic                                ready;
    logic [mtlfo_pkg::CH_W-1:0]          channel;
    logic signed [mtlfo_pkg::VOLT_W-1:0] level;
    logic                                last;

    modport source (output valid, channel, level, last, input ready);
    modport sink   (input valid, channel, level, last, output ready);
endinterface

interface mtlfo_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mtlfo_pkg::CFG_IDX_W-1:0]     index;
    logic [mtlfo_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/mtlfo_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO configuration registers
// Register file written through the configuration channel.
// ----------------------------------------------------------------------------
module mtlfo_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [mtlfo_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [mtlfo_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output mtlfo_pkg::t_cfg                    o_cfg
);

    mtlfo_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= mtlfo_pkg::RST_CHANNEL_COUNT;
            r_cfg.rate_knob_bpm <= mtlfo_pkg::RST_RATE_KNOB_BPM;
            r_cfg.min_knob      <= mtlfo_pkg::RST_MIN_KNOB;
            r_cfg.max_knob      <= mtlfo_pkg::RST_MAX_KNOB;
            r_cfg.use_rate_cv   <= 1'b0;
            r_cfg.use_min_cv    <= 1'b0;
            r_cfg.use_max_cv    <= 1'b0;
            r_cfg.step_per_bpm  <= mtlfo_pkg::RST_STEP_PER_BPM;
        end else if (i_wr_en) begin
            unique case (mtlfo_pkg::t_reg_idx'(i_wr_index))
                mtlfo_pkg::REG_CHANNEL_COUNT: begin
                    r_cfg.channel_count <= i_wr_data[mtlfo_pkg::COUNT_W-1:0];
                end
                mtlfo_pkg::REG_RATE_KNOB_BPM: begin
                    r_cfg.rate_knob_bpm <= i_wr_data[mtlfo_pkg::BPM_W-1:0];
                end
                mtlfo_pkg::REG_MIN_KNOB: begin
                    r_cfg.min_knob <= $signed(i_wr_data[mtlfo_pkg::VOLT_W-1:0]);
                end
                mtlfo_pkg::REG_MAX_KNOB: begin
                    r_cfg.max_knob <= $signed(i_wr_data[mtlfo_pkg::VOLT_W-1:0]);
                end
                mtlfo_pkg::REG_USE_RATE_CV: begin
                    r_cfg.use_rate_cv <= i_wr_data[0];
                end
                mtlfo_pkg::REG_USE_MIN_CV: begin
                    r_cfg.use_min_cv <= i_wr_data[0];
                end
                mtlfo_pkg::REG_USE_MAX_CV: begin
                    r_cfg.use_max_cv <= i_wr_data[0];
                end
                mtlfo_pkg::REG_STEP_PER_BPM: begin
                    r_cfg.step_per_bpm <= i_wr_data[mtlfo_pkg::STEP_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/mtlfo_ctrl.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO controller
// Sequences the rate/divider sweep and the per-channel level steps.
// ----------------------------------------------------------------------------
`include "multiphase_triangle_lfo_defines.svh"

module mtlfo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mtlfo_pkg::t_sts   i_sts,
    output mtlfo_pkg::t_cmd   o_cmd
);

    localparam int CW = mtlfo_pkg::PREP_CNT_W;

    mtlfo_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            mtlfo_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = mtlfo_pkg::S_PREP;
                end
            end
            mtlfo_pkg::S_PREP: begin
                // divider runs every cycle; the rate path rides along early on
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == CW'(0));
                o_cmd.rate_mul  = (r_cnt == CW'(mtlfo_pkg::PREP_RATE_MUL));
                o_cmd.bpm_sel   = (r_cnt == CW'(mtlfo_pkg::PREP_BPM));
                o_cmd.inc_mul   = (r_cnt == CW'(mtlfo_pkg::PREP_INC));
                o_cmd.phase_add = (r_cnt == CW'(mtlfo_pkg::PREP_ADD));
                if (r_cnt == CW'(mtlfo_pkg::PREP_LAST)) begin
                    n_state = i_sts.n_zero ? mtlfo_pkg::S_IDLE : mtlfo_pkg::S_PH;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            mtlfo_pkg::S_PH: begin
                o_cmd.mag = 1'b1;
                n_state   = mtlfo_pkg::S_MLO;
            end
            mtlfo_pkg::S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = mtlfo_pkg::S_MHI;
            end
            mtlfo_pkg::S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = mtlfo_pkg::S_FIN;
            end
            mtlfo_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = i_sts.last_ch ? mtlfo_pkg::S_IDLE : mtlfo_pkg::S_PH;
                end
            end
            default: begin
                n_state = mtlfo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtlfo_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == mtlfo_pkg::S_IDLE);

    `MTLFO_ASSERT_NXT(a_last_level_ends_item, i_clk, i_rst_n,
        o_cmd.load_out && i_sts.last_ch, r_state == mtlfo_pkg::S_IDLE)
    `MTLFO_ASSERT_NXT(a_zero_channels_skip, i_clk, i_rst_n,
        o_cmd.div_step && (r_cnt == CW'(mtlfo_pkg::PREP_LAST)) && i_sts.n_zero,
        r_state == mtlfo_pkg::S_IDLE)

endmodule

// ----- rtl/core/mtlfo_dp.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO datapath
// Rate, phase accumulator, channel offset divider and level arithmetic.
// ----------------------------------------------------------------------------
`include "multiphase_triangle_lfo_defines.svh"

module mtlfo_dp #(
    parameter int MAX_CHANNELS = mtlfo_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtlfo_pkg::t_cfg                     i_cfg,
    input  mtlfo_pkg::t_cmd                     i_cmd,
    output mtlfo_pkg::t_sts                     o_sts,
    input  logic signed [mtlfo_pkg::VOLT_W-1:0] i_rate_cv,
    input  logic signed [mtlfo_pkg::VOLT_W-1:0] i_min_cv,
    input  logic signed [mtlfo_pkg::VOLT_W-1:0] i_max_cv,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mtlfo_pkg::CH_W-1:0]          o_channel,
    output logic signed [mtlfo_pkg::VOLT_W-1:0] o_level,
    output logic                                o_last
);

    localparam int VW  = mtlfo_pkg::VOLT_W;
    localparam int DW  = mtlfo_pkg::DIFF_W;
    localparam int NW  = mtlfo_pkg::COUNT_W;
    localparam int PW  = mtlfo_pkg::PHASE_W;
    localparam int HW  = mtlfo_pkg::HALF_W;
    localparam int AW  = mtlfo_pkg::ACC_W;
    localparam int RPW = mtlfo_pkg::RATE_PROD_W;
    localparam int BRW = mtlfo_pkg::BPM_RAW_W;
    localparam int IPW = mtlfo_pkg::INC_PROD_W;
    localparam int BW  = mtlfo_pkg::BPM_W;

    // item registers
    logic signed [VW-1:0]  r_rate_cv;
    logic signed [VW-1:0]  r_lo;
    logic signed [DW-1:0]  r_diff;

    // rate path
    logic signed [RPW-1:0] r_rate_prod;
    logic [BW-1:0]         r_bpm;
    logic [mtlfo_pkg::INC_W-1:0] r_inc;
    logic [PW-1:0]         r_base;

    // 2^32 / n
    logic [NW-1:0]         r_drem;
    logic [PW-1:0]         r_quot;

    // channel walk
    logic [NW-1:0]         r_ch;
    logic [PW-1:0]         r_off;
    logic [NW-1:0]         r_racc;
    logic [PW-1:0]         r_mag;
    logic signed [AW-1:0]  r_acc;

    // output register
    logic                  r_out_valid;
    logic [mtlfo_pkg::CH_W-1:0] r_out_channel;
    logic signed [VW-1:0]  r_out_level;
    logic                  r_out_last;

    logic [NW-1:0]         w_n;
    logic signed [VW-1:0]  w_lo_sel;
    logic signed [VW-1:0]  w_hi_sel;
    logic signed [RPW-1:0] w_rate_round;
    logic signed [BRW-1:0] w_bpm_raw;
    logic [BW-1:0]         w_bpm_cv;
    logic [IPW-1:0]        w_inc_prod;
    logic [1:0]            w_dpair;
    logic [NW:0]           w_ds1;
    logic [NW:0]           w_ds2;
    logic [NW:0]           w_racc_sum;
    logic                  w_racc_wrap;
    logic [PW-1:0]         w_p;
    logic signed [HW:0]    w_mag_lo;
    logic signed [HW:0]    w_mag_hi;
    logic signed [mtlfo_pkg::PPROD_W-1:0] w_prod_lo;
    logic signed [mtlfo_pkg::PPROD_W-1:0] w_prod_hi;
    logic signed [AW-1:0]  w_acc_rnd;
    logic signed [VW-1:0]  w_level;

    always_comb begin
        if (int'(i_cfg.channel_count) > MAX_CHANNELS) begin
            w_n = NW'(MAX_CHANNELS);
        end else begin
            w_n = i_cfg.channel_count;
        end
    end

    assign w_lo_sel = i_cfg.use_min_cv ? i_min_cv : i_cfg.min_knob;
    assign w_hi_sel = i_cfg.use_max_cv ? i_max_cv : i_cfg.max_knob;

    // bpm from CV, floor after adding half an LSB
    assign w_rate_round = r_rate_prod + RPW'(mtlfo_pkg::RATE_ROUND);
    assign w_bpm_raw = BRW'($signed(w_rate_round[RPW-1:mtlfo_pkg::RATE_SHIFT]))
                     + BRW'(mtlfo_pkg::RATE_OFFSET);

    always_comb begin
        if (w_bpm_raw[BRW-1]) begin
            w_bpm_cv = '0;
        end else if (w_bpm_raw > BRW'(mtlfo_pkg::BPM_MAX)) begin
            w_bpm_cv = BW'(mtlfo_pkg::BPM_MAX);
        end else begin
            w_bpm_cv = w_bpm_raw[BW-1:0];
        end
    end

    assign w_inc_prod = IPW'(r_bpm) * IPW'(i_cfg.step_per_bpm);

    // dividend is 2^32: only the first pair carries a one
    assign w_dpair = i_cmd.div_first ? 2'b01 : 2'b00;
    assign w_ds1   = mtlfo_pkg::div_step(r_drem, w_dpair[1], w_n);
    assign w_ds2   = mtlfo_pkg::div_step(w_ds1[NW-1:0], w_dpair[0], w_n);

    // offset_i = floor(i * 2^32 / n), kept as quotient plus running remainder
    assign w_racc_sum  = {1'b0, r_racc} + {1'b0, r_drem};
    assign w_racc_wrap = (w_racc_sum >= {1'b0, w_n});

    assign w_p      = r_base + r_off;
    assign w_mag_lo = $signed({1'b0, r_mag[HW-1:0]});
    assign w_mag_hi = $signed({1'b0, r_mag[PW-1:HW]});
    assign w_prod_lo = r_diff * w_mag_lo;
    assign w_prod_hi = r_diff * w_mag_hi;

    assign w_acc_rnd = r_acc + $signed(mtlfo_pkg::LEVEL_ROUND);
    assign w_level   = r_lo + VW'(w_acc_rnd >>> mtlfo_pkg::LEVEL_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rate_cv <= i_rate_cv;
            r_lo      <= w_lo_sel;
            r_diff    <= DW'(w_hi_sel) - DW'(w_lo_sel);
            r_drem    <= '0;
            r_ch      <= '0;
            r_off     <= '0;
            r_racc    <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= w_ds2[NW-1:0];
            r_quot <= {r_quot[PW-3:0], w_ds1[NW], w_ds2[NW]};
        end
        if (i_cmd.rate_mul) begin
            r_rate_prod <= RPW'(r_rate_cv) * RPW'(mtlfo_pkg::RATE_GAIN);
        end
        if (i_cmd.bpm_sel) begin
            r_bpm <= i_cfg.use_rate_cv ? w_bpm_cv : i_cfg.rate_knob_bpm;
        end
        if (i_cmd.inc_mul) begin
            r_inc <= w_inc_prod[IPW-1:mtlfo_pkg::INC_SHIFT];
        end
        if (i_cmd.mag) begin
            // -2^31 negates to itself, which is the right magnitude
            r_mag <= w_p[PW-1] ? (~w_p + PW'(1)) : w_p;
        end
        if (i_cmd.mlo) begin
            r_acc <= AW'(w_prod_lo);
        end
        if (i_cmd.mhi) begin
            r_acc <= r_acc + (AW'(w_prod_hi) <<< HW);
        end
        if (i_cmd.load_out) begin
            r_out_channel <= r_ch[mtlfo_pkg::CH_W-1:0];
            r_out_level   <= w_level;
            r_out_last    <= o_sts.last_ch;
            r_ch          <= r_ch + NW'(1);
            r_off         <= r_off + r_quot + PW'(w_racc_wrap);
            r_racc        <= w_racc_wrap ? NW'(w_racc_sum - {1'b0, w_n})
                                         : w_racc_sum[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.phase_add) begin
                r_base <= r_base + PW'(r_inc);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.n_zero   = (w_n == '0);
    assign o_sts.last_ch  = (({1'b0, r_ch} + (NW + 1)'(1)) == {1'b0, w_n});
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_out_channel;
    assign o_level     = r_out_level;
    assign o_last      = r_out_last;

    `MTLFO_ASSERT_IMP(a_offset_rem_below_n, i_clk, i_rst_n,
        i_cmd.load_out, r_racc < w_n)
    `MTLFO_ASSERT_NXT(a_div_rem_below_n, i_clk, i_rst_n,
        i_cmd.div_step && (w_n != '0), r_drem < w_n)

endmodule

// ----- rtl/core/multiphase_triangle_lfo.sv -----
// ----------------------------------------------------------------------------
// Multiphase triangle LFO
// Phase-accumulator LFO emitting one triangle level per channel and tick.
// ----------------------------------------------------------------------------
//  port    dir  role                  payload
//  i_in    in   sample tick           rate_cv, min_cv, max_cv (Q4.12)
//  o_out   out  level per channel     channel, level (Q4.12), last
//  i_cfg   in   register write        index, data
//
//  An item is accepted, then the 2^32/n divider runs (two bits a cycle; the
//  rate multiply and phase add run alongside), then each channel steps through
//  magnitude, low and high halves of the split 18x16 multiply, and output load.
//  Output back-pressure stretches only the final step of each channel.
//  Reset is synchronous: config registers take their reset values, phase goes to 0.
//  Register writes are always ready.
// ----------------------------------------------------------------------------
module multiphase_triangle_lfo #(
    parameter int MAX_CHANNELS = mtlfo_pkg::MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtlfo_in_if.sink    i_in,
    mtlfo_out_if.source o_out,
    mtlfo_cfg_if.sink   i_cfg
);

    mtlfo_pkg::t_cfg w_cfg;
    mtlfo_pkg::t_cmd w_cmd;
    mtlfo_pkg::t_sts w_sts;
    logic            w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    mtlfo_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    mtlfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtlfo_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rate_cv   (i_in.rate_cv),
        .i_min_cv    (i_in.min_cv),
        .i_max_cv    (i_in.max_cv),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_channel   (o_out.channel),
        .o_level     (o_out.level),
        .o_last      (o_out.last)
    );

endmodule
